>>> hdl/grr_pkg.sv
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types and constants of the glyph row to page column renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

	localparam int unsigned GLYPH_BYTES = 32;
	localparam int unsigned HALF_LEN    = 19;

	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] MASK_HI    = 8'hF0;
	localparam logic [7:0] MASK_LO    = 8'h0F;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		K_PAGE,
		K_COL_HI,
		K_COL_LO,
		K_DATA
	} kind_t;

	typedef struct packed {
		logic  load;
		logic  latch;
		logic  emit;
		kind_t kind;
		logic  half;
		logic  side;
		logic  last;
	} ctl_t;

endpackage

`default_nettype wire

>>> hdl/grr_seq.sv
// ----------------------------------------------------------------------------
// grr_seq
// Sequencer: counts loaded words, then steps through the 38 output words.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_seq
	import grr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output ctl_t      ctl
);

	localparam int unsigned LOAD_W = $clog2(GLYPH_BYTES);
	localparam int unsigned POS_W  = $clog2(HALF_LEN);

	state_t             state_q, state_d;
	logic [LOAD_W-1:0]  load_cnt_q, load_cnt_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic               half_q, half_d;
	logic               accept;
	logic [POS_W-1:0]   col_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			pos_q      <= '0;
			half_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			load_cnt_q <= load_cnt_d;
			pos_q      <= pos_d;
			half_q     <= half_d;
		end
	end

	assign col_idx = pos_q - POS_W'(3);

	always_comb begin
		state_d    = state_q;
		load_cnt_d = load_cnt_q;
		pos_d      = pos_q;
		half_d     = half_q;
		busy       = 1'b0;
		accept     = 1'b0;
		ctl        = '0;
		ctl.kind   = K_PAGE;
		ctl.half   = half_q;
		ctl.side   = col_idx[3];
		case (state_q)
			ST_LOAD: begin
				accept   = start;
				ctl.load = start;
				if (start) begin
					load_cnt_d = load_cnt_q + LOAD_W'(1);
					if (load_cnt_q == LOAD_W'(GLYPH_BYTES - 1)) begin
						ctl.latch = 1'b1;
						state_d   = ST_EMIT;
						pos_d     = '0;
						half_d    = 1'b0;
					end
				end
			end
			ST_EMIT: begin
				busy     = 1'b1;
				ctl.emit = 1'b1;
				case (pos_q)
					POS_W'(0): ctl.kind = K_PAGE;
					POS_W'(1): ctl.kind = K_COL_HI;
					POS_W'(2): ctl.kind = K_COL_LO;
					default:   ctl.kind = K_DATA;
				endcase
				if (pos_q == POS_W'(HALF_LEN - 1)) begin
					pos_d = '0;
					if (half_q) begin
						ctl.last = 1'b1;
						state_d  = ST_LOAD;
					end else begin
						half_d = 1'b1;
					end
				end else begin
					pos_d = pos_q + POS_W'(1);
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

`ifndef SYNTH
	a_latch_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.latch |=> (ctl.emit && pos_q == '0 && !half_q))
		else $error("run did not start after last load");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && !ctl.last) |=> ctl.emit)
		else $error("run ended early");
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.last) |=> (!ctl.emit && load_cnt_q == '0))
		else $error("run did not end cleanly");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (pos_q <= POS_W'(HALF_LEN - 1)))
		else $error("position out of range");
	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !accept)
		else $error("word loaded during run");
`endif

endmodule

`default_nettype wire

>>> hdl/grr_store.sv
// ----------------------------------------------------------------------------
// grr_store
// Glyph shift line with a shared column extractor: each data step takes the
// MSBs of the selected eight row bytes and shifts those bytes left by one.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_store
	import grr_pkg::*;
(
	input  wire logic       clk,
	input  wire ctl_t       ctl,
	input  wire logic [7:0] glyph_byte,
	output logic [7:0]      col_byte
);

	logic [7:0] glyph_q [GLYPH_BYTES];
	logic       shift_en;

	assign shift_en = ctl.emit && (ctl.kind == K_DATA);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < GLYPH_BYTES - 1; i++) begin
				glyph_q[i] <= glyph_q[i+1];
			end
			glyph_q[GLYPH_BYTES-1] <= glyph_byte;
		end else if (shift_en) begin
			for (int i = 0; i < GLYPH_BYTES; i++) begin
				if ((5'(i) >> 4) == {4'd0, ctl.half} && 5'(i) % 2 == {4'd0, ctl.side}) begin
					glyph_q[i] <= {glyph_q[i][6:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 8; r++) begin
			col_byte[r] = glyph_q[{ctl.half, 3'(r), ctl.side}][7];
		end
	end

endmodule

`default_nettype wire

>>> hdl/glyph_row_to_page_column_renderer.sv
// ----------------------------------------------------------------------------
// glyph_row_to_page_column_renderer
// Turns the 32 row-scan words of a 16x16 glyph into cursor commands and
// page-column data words for a page-addressed panel.
// One word is accepted per cycle while busy is low; the 32nd word starts a run
// in which the sequencer's emit state drives 38 words on consecutive cycles
// through the output register, the single column shifter producing one data
// word per cycle; busy is high during the run, and no word is accepted then.
// Reset clears the sequencer and strobe; the glyph store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_to_page_column_renderer
	import grr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] glyph_byte,
	input  wire logic [2:0] start_page,
	input  wire logic [6:0] start_column,
	output logic            strobe,
	output logic [7:0]      out_byte,
	output logic            is_data,
	output logic            last_of_run
);

	ctl_t       ctl;
	logic [7:0] col_byte;
	logic [2:0] page_q;
	logic [6:0] column_q;
	logic [2:0] page_cur;
	logic [7:0] col8;
	logic [7:0] byte_d;
	logic       strobe_q;
	logic [7:0] out_byte_q;
	logic       is_data_q;
	logic       last_q;

	grr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	grr_store u_store (
		.clk        (clk),
		.ctl        (ctl),
		.glyph_byte (glyph_byte),
		.col_byte   (col_byte)
	);

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			page_q   <= start_page;
			column_q <= start_column;
		end
	end

	assign page_cur = page_q + {2'd0, ctl.half};
	assign col8     = {1'b0, column_q};

	always_comb begin
		case (ctl.kind)
			K_PAGE:   byte_d = CMD_PAGE | {5'd0, page_cur};
			K_COL_HI: byte_d = CMD_COL_HI | ((col8 & MASK_HI) >> 4);
			K_COL_LO: byte_d = col8 & MASK_LO;
			K_DATA:   byte_d = col_byte;
			default:  byte_d = col_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_byte_q <= byte_d;
			is_data_q  <= (ctl.kind == K_DATA);
			last_q     <= ctl.last;
		end
	end

	assign strobe      = strobe_q;
	assign out_byte    = out_byte_q;
	assign is_data     = is_data_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

>>> bench/glyph_render_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_render_checker
// Watches the load and run channels of the glyph renderer, keeps its own copy
// of the glyph rows, predicts the 38 panel words of every glyph and compares
// each strobed word with the oldest prediction.
// ----------------------------------------------------------------------------

module glyph_render_checker
	import grr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       busy,
	input  wire logic [7:0] glyph_byte,
	input  wire logic [2:0] start_page,
	input  wire logic [6:0] start_column,
	input  wire logic       strobe,
	input  wire logic [7:0] out_byte,
	input  wire logic       is_data,
	input  wire logic       last_of_run,
	output int              mismatches,
	output int              words_due
);

	typedef struct packed {
		logic [7:0] value;
		logic       is_data;
		logic       last;
	} panel_word_t;

	logic [7:0]  glyph_rows [GLYPH_BYTES];
	logic [4:0]  rows_loaded;
	panel_word_t panel_words [$];

	initial begin
		mismatches = 0;
		words_due  = 0;
	end

	// bit r = pixel of glyph row 8*half+r in column col
	function automatic logic [7:0] column_word(input int half, input int col);
		logic [7:0] v;
		int         r;
		for (r = 0; r < 8; r++) begin
			v[r] = glyph_rows[(half * 8 + r) * 2 + col / 8][7 - col % 8];
		end
		return v;
	endfunction

	task automatic render_glyph(input logic [2:0] page, input logic [6:0] col);
		logic [2:0] pg;
		int         h;
		int         c;
		for (h = 0; h < 2; h++) begin
			pg = page + 3'(h);
			panel_words.push_back('{CMD_PAGE | {5'd0, pg}, 1'b0, 1'b0});
			panel_words.push_back('{CMD_COL_HI | {5'd0, col[6:4]}, 1'b0, 1'b0});
			panel_words.push_back('{MASK_LO & {4'd0, col[3:0]}, 1'b0, 1'b0});
			for (c = 0; c < 16; c++)
				panel_words.push_back('{column_word(h, c), 1'b1, (h == 1 && c == 15)});
		end
	endtask

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		panel_word_t want;
		if (!arst_n) begin
			rows_loaded = '0;
			panel_words.delete();
			words_due = 0;
		end else begin
			if (start && !busy) begin
				glyph_rows[rows_loaded] = glyph_byte;
				if (rows_loaded == 5'(GLYPH_BYTES - 1))
					render_glyph(start_page, start_column);
				rows_loaded = rows_loaded + 5'd1;
			end
			if (strobe) begin
				if (panel_words.size() == 0) begin
					report($sformatf("unexpected word out_byte=%h is_data=%b last=%b",
						out_byte, is_data, last_of_run));
				end else begin
					want = panel_words.pop_front();
					if (out_byte !== want.value || is_data !== want.is_data ||
						last_of_run !== want.last)
						report($sformatf("out_byte %h/%h is_data %b/%b last %b/%b (exp/got)",
							want.value, out_byte, want.is_data, is_data,
							want.last, last_of_run));
				end
			end
			words_due = panel_words.size();
		end
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Loads glyphs into the renderer: one directed glyph with diagonal patterns
// and extreme cursor values, then random glyphs under three sender idle
// profiles and a trailing partial glyph. The checker judges every word.
// ----------------------------------------------------------------------------

module tb;
	import grr_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] glyph_byte;
	logic [2:0] start_page;
	logic [6:0] start_column;
	logic       strobe;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last_of_run;
	int         mismatches;
	int         words_due;
	int         sender_idle;

	glyph_row_to_page_column_renderer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.glyph_byte   (glyph_byte),
		.start_page   (start_page),
		.start_column (start_column),
		.strobe       (strobe),
		.out_byte     (out_byte),
		.is_data      (is_data),
		.last_of_run  (last_of_run)
	);

	glyph_render_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.glyph_byte   (glyph_byte),
		.start_page   (start_page),
		.start_column (start_column),
		.strobe       (strobe),
		.out_byte     (out_byte),
		.is_data      (is_data),
		.last_of_run  (last_of_run),
		.mismatches   (mismatches),
		.words_due    (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// returns just after the edge that accepted the word
	task automatic send_word(input logic [7:0] b, input logic [2:0] p, input logic [6:0] c);
		while ($urandom_range(0, 99) < sender_idle) begin
			start      <= 1'b0;
			glyph_byte <= 8'($urandom);
			@(posedge clk);
		end
		start        <= 1'b1;
		glyph_byte   <= b;
		start_page   <= p;
		start_column <= c;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [7:0] b;
		logic [6:0] col;
		int         i;
		int         g;
		int         tail;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		glyph_byte   <= '0;
		start_page   <= '0;
		start_column <= '0;
		sender_idle  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// diagonals, all-ones and all-zeros rows; page 7 wraps the lower half to page 0
		for (i = 0; i < 32; i++) begin
			b = i[0] ? ~(8'h01 << (i / 2 % 8)) : (8'h80 >> (i / 2 % 8));
			if (i == 28) b = 8'hFF;
			if (i == 29) b = 8'h00;
			if (i == 31)
				send_word(b, 3'd7, 7'd127);
			else
				send_word(b, i[0] ? 3'd7 : 3'd0, i[0] ? 7'd127 : 7'd0);
		end

		for (g = 0; g < 13; g++) begin
			sender_idle = (g < 5) ? 37 : (g < 9) ? 59 : 0;
			for (i = 0; i < 32; i++) begin
				case ($urandom_range(0, 7))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0:       col = 7'd0;
					1:       col = 7'd127;
					default: col = 7'($urandom_range(0, 127));
				endcase
				send_word(b, 3'($urandom_range(0, 7)), col);
			end
		end

		// partial glyph: must produce nothing
		tail = $urandom_range(1, 31);
		for (i = 0; i < tail; i++)
			send_word(8'($urandom), 3'($urandom), 7'($urandom));
		start <= 1'b0;

		@(negedge clk);
		while (words_due != 0) @(negedge clk);
		repeat (45) @(posedge clk);
		if (mismatches == 0 && words_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> glyph_row_to_page_column_renderer.f
hdl/grr_pkg.sv
hdl/grr_seq.sv
hdl/grr_store.sv
hdl/glyph_row_to_page_column_renderer.sv
bench/glyph_render_checker.sv
bench/tb.sv
